/* hw/rtl/dpid_pkg.sv */
// Shared types and constants for the distance PID drive controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package dpid_pkg;

  localparam logic [3:0]  RAMP_TICKS   = 4'd10;
  localparam logic [3:0]  SETTLE_LIMIT = 4'd10;
  localparam logic [9:0]  STALL_LIMIT  = 10'd1000;
  // 12000/127 in Q8.8
  localparam logic [23:0] OUT_SCALE    = 24'd24189;
  localparam int          MUL_STEPS    = 24;

  localparam logic MODE_START = 1'b0;

  localparam logic [1:0] STOP_RUN     = 2'd0;
  localparam logic [1:0] STOP_SETTLED = 2'd1;
  localparam logic [1:0] STOP_STALLED = 2'd2;

  typedef enum logic [2:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_TARGET_DISTANCE = 3'd3,
    REG_SPEED_CEILING   = 3'd4,
    REG_SPEED_FLOOR     = 3'd5,
    REG_SETTLE_TOL      = 3'd6,
    REG_HEADING_HOLD    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               mode;
    logic signed [23:0] left_position;
    logic signed [23:0] right_position;
    logic signed [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_command;
    logic signed [31:0] right_command;
    logic               command_is_voltage;
    logic               finished;
    logic [1:0]         stop_reason;
  } out_item_t;

  typedef struct packed {
    logic [23:0]        gain_p;
    logic [23:0]        gain_i;
    logic [23:0]        gain_d;
    logic signed [15:0] target_distance;
    logic signed [15:0] speed_ceiling;
    logic signed [15:0] speed_floor;
    logic [15:0]        settle_tolerance;
    logic               heading_hold;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [47:0] mcand;
    logic [23:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [71:0] product;
  } mul_rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/drive_distance_pid_with_heading_hold.sv */
// Top level of the distance PID drive controller with heading hold.
// Depends on dpid_pkg, dpid_cfg and dpid_mul.
//
//   channel | direction | handshake           | beat
//   in_     | input     | in_valid / in_stall   | in_item_t (mode, positions, heading)
//   out_    | output    | out_valid / out_stall | out_item_t (commands, flags)
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A control tick makes seven passes through the shared 24-step shift-and-add
// multiplier (three PID terms, two clamp tests, two command scalings) besides
// its other states. Start beats and ticks after the move stopped go straight
// from S_IDLE to S_OUT without the multiplier. One beat is in flight at a time;
// a finished result sits in the output register so the next beat can be taken
// while it waits. rst_n is synchronous; cfg_ready is always high.
`default_nettype none
module drive_distance_pid_with_heading_hold import dpid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'b000000000000000001,
    S_ERR      = 18'b000000000000000010,
    S_UPD      = 18'b000000000000000100,
    S_MUL_P    = 18'b000000000000001000,
    S_MUL_I    = 18'b000000000000010000,
    S_MUL_D    = 18'b000000000000100000,
    S_CLAMP    = 18'b000000000001000000,
    S_CEIL_GO  = 18'b000000000010000000,
    S_CEIL     = 18'b000000000100000000,
    S_FLOOR_GO = 18'b000000001000000000,
    S_FLOOR    = 18'b000000010000000000,
    S_TURN     = 18'b000000100000000000,
    S_OPS      = 18'b000001000000000000,
    S_CMDL_GO  = 18'b000010000000000000,
    S_CMD_L    = 18'b000100000000000000,
    S_CMD_R    = 18'b001000000000000000,
    S_FINISH   = 18'b010000000000000000,
    S_OUT      = 18'b100000000000000000
  } state_t;

  localparam logic signed [65:0] V_HI = 66'sd35184372088832;
  localparam logic signed [65:0] V_LO = -66'sd35184372088832;

  function automatic logic [47:0] abs48(input logic signed [47:0] x);
    return x[47] ? 48'(-x) : 48'(x);
  endfunction

  function automatic logic signed [65:0] sterm(input logic neg, input logic [62:0] mag);
    logic signed [65:0] m;
    m = $signed({3'b0, mag});
    return neg ? -m : m;
  endfunction

  // product >> 25, truncated toward zero and saturated to 32 bits
  function automatic logic [31:0] to_cmd(input logic neg, input logic [36:0] qm);
    logic [31:0] r;
    if (neg) begin
      r = (qm > 37'h080000000) ? 32'h80000000 : 32'(-qm[31:0]);
    end else begin
      r = (qm > 37'h07FFFFFFF) ? 32'h7FFFFFFF : qm[31:0];
    end
    return r;
  endfunction

  cfg_t     cfg;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  state_t state_r, state_nxt;

  // loop state
  logic signed [15:0] href_r, href_nxt;
  logic signed [24:0] poff_r, poff_nxt;
  logic signed [27:0] prev_r, prev_nxt;
  logic signed [47:0] integ_r, integ_nxt;
  logic [3:0]         tick_r, tick_nxt;
  logic [3:0]         settle_r, settle_nxt;
  logic [9:0]         stall_r, stall_nxt;
  logic               done_r, done_nxt;
  logic [1:0]         reason_r, reason_nxt;

  // per-tick work registers
  logic signed [15:0] head_r, head_nxt;
  logic signed [25:0] dist_r, dist_nxt;
  logic signed [27:0] e_r, e_nxt;
  logic signed [27:0] d_r, d_nxt;
  logic signed [65:0] sum_r, sum_nxt;
  logic signed [46:0] v_r, v_nxt;
  logic signed [35:0] turn_r, turn_nxt;
  logic signed [47:0] opl_r, opl_nxt;
  logic signed [47:0] opr_r, opr_nxt;
  logic [31:0]        lc_r, lc_nxt;
  logic [31:0]        rc_r, rc_nxt;
  out_item_t          res_r, res_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic               in_take, out_take;
  logic signed [22:0] t96;
  logic signed [27:0] t96_e;
  logic signed [48:0] isum;
  logic [27:0]        emag;
  logic [62:0]        isat_mag;
  logic               isat;
  logic signed [63:0] pscale;
  logic signed [63:0] ceil_q25, floor_q25;
  logic signed [16:0] hdiff;
  logic signed [17:0] hdx, hwrap;
  logic signed [47:0] v_ext;

  dpid_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dpid_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;

  assign t96   = $signed({cfg.target_distance[15], cfg.target_distance, 6'b0})
               + $signed({{2{cfg.target_distance[15]}}, cfg.target_distance, 5'b0});
  assign t96_e = {{5{t96[22]}}, t96};

  assign isum = $signed({integ_r[47], integ_r}) + $signed({{21{e_r[27]}}, e_r});
  assign emag = e_r[27] ? 28'(-e_r) : 28'(e_r);

  // integral product saturates above 2^62
  assign isat     = (|mrsp.product[71:63]) || (mrsp.product[62] && (|mrsp.product[61:0]));
  assign isat_mag = isat ? {1'b1, 62'b0} : mrsp.product[62:0];

  assign pscale = v_r[46] ? -$signed({2'b0, mrsp.product[61:0]})
                          : $signed({2'b0, mrsp.product[61:0]});
  assign ceil_q25  = $signed({{23{cfg.speed_ceiling[15]}}, cfg.speed_ceiling, 25'b0});
  assign floor_q25 = $signed({{23{cfg.speed_floor[15]}}, cfg.speed_floor, 25'b0});

  assign hdiff = $signed({href_r[15], href_r}) - $signed({head_r[15], head_r});
  assign hdx   = {hdiff[16], hdiff};
  always_comb begin
    if (hdx > 18'sd180) begin
      hwrap = hdx - 18'sd360;
    end else if (hdx < -18'sd180) begin
      hwrap = hdx + 18'sd360;
    end else begin
      hwrap = hdx;
    end
  end
  assign v_ext = {v_r[46], v_r};

  always_comb begin
    state_nxt  = state_r;
    href_nxt   = href_r;
    poff_nxt   = poff_r;
    prev_nxt   = prev_r;
    integ_nxt  = integ_r;
    tick_nxt   = tick_r;
    settle_nxt = settle_r;
    stall_nxt  = stall_r;
    done_nxt   = done_r;
    reason_nxt = reason_r;
    head_nxt   = head_r;
    dist_nxt   = dist_r;
    e_nxt      = e_r;
    d_nxt      = d_r;
    sum_nxt    = sum_r;
    v_nxt      = v_r;
    turn_nxt   = turn_r;
    opl_nxt    = opl_r;
    opr_nxt    = opr_r;
    lc_nxt     = lc_r;
    rc_nxt     = rc_r;
    res_nxt    = res_r;
    mreq       = '0;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_data.mode == MODE_START) begin
            href_nxt   = in_data.heading;
            poff_nxt   = 25'(in_data.left_position) + 25'(in_data.right_position);
            prev_nxt   = '0;
            integ_nxt  = '0;
            tick_nxt   = '0;
            settle_nxt = '0;
            stall_nxt  = '0;
            done_nxt   = 1'b0;
            reason_nxt = STOP_RUN;
            res_nxt    = '0;
            state_nxt  = S_OUT;
          end else if (done_r) begin
            res_nxt = '0;
            res_nxt.command_is_voltage = cfg.heading_hold;
            res_nxt.finished           = 1'b1;
            res_nxt.stop_reason        = reason_r;
            state_nxt = S_OUT;
          end else begin
            head_nxt  = in_data.heading;
            dist_nxt  = 26'(in_data.left_position) + 26'(in_data.right_position)
                      - 26'(poff_r);
            state_nxt = S_ERR;
          end
        end
      end

      S_ERR: begin
        e_nxt     = t96_e - 28'(dist_r);
        state_nxt = S_UPD;
      end

      S_UPD: begin
        if (isum[48] != isum[47]) begin
          integ_nxt = isum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
          integ_nxt = isum[47:0];
        end
        // integral resets on zero error or when the error exceeds the target (negative distance)
        if (e_r == 28'sd0 || e_r > t96_e) begin
          integ_nxt = '0;
        end
        d_nxt    = e_r - prev_r;
        prev_nxt = e_r;
        if (tick_r <= RAMP_TICKS) begin
          tick_nxt = tick_r + 4'd1;
        end
        if (emag < {11'b0, cfg.settle_tolerance, 1'b0}) begin
          settle_nxt = (settle_r <= SETTLE_LIMIT) ? settle_r + 4'd1 : settle_r;
        end else begin
          settle_nxt = '0;
        end
        if (settle_nxt > SETTLE_LIMIT) begin
          done_nxt   = 1'b1;
          reason_nxt = STOP_SETTLED;
        end else begin
          if (e_r == prev_r) begin
            stall_nxt = (stall_r < STALL_LIMIT) ? stall_r + 10'd1 : stall_r;
          end else begin
            stall_nxt = '0;
          end
          if (stall_nxt >= STALL_LIMIT) begin
            done_nxt   = 1'b1;
            reason_nxt = STOP_STALLED;
          end
        end
        mreq.start  = 1'b1;
        mreq.mcand  = abs48({{20{e_r[27]}}, e_r});
        mreq.mplier = cfg.gain_p;
        state_nxt   = S_MUL_P;
      end

      S_MUL_P: begin
        if (mrsp.done) begin
          sum_nxt     = sterm(e_r[27], {11'b0, mrsp.product[51:0]});
          mreq.start  = 1'b1;
          mreq.mcand  = abs48(integ_r);
          mreq.mplier = cfg.gain_i;
          state_nxt   = S_MUL_I;
        end
      end

      S_MUL_I: begin
        if (mrsp.done) begin
          sum_nxt     = sum_r + sterm(integ_r[47], isat_mag);
          mreq.start  = 1'b1;
          mreq.mcand  = abs48({{20{d_r[27]}}, d_r});
          mreq.mplier = cfg.gain_d;
          state_nxt   = S_MUL_D;
        end
      end

      S_MUL_D: begin
        if (mrsp.done) begin
          sum_nxt   = sum_r + sterm(d_r[27], {10'b0, mrsp.product[52:0]});
          state_nxt = S_CLAMP;
        end
      end

      S_CLAMP: begin
        if (sum_r > V_HI) begin
          v_nxt = V_HI[46:0];
        end else if (sum_r < V_LO) begin
          v_nxt = V_LO[46:0];
        end else begin
          v_nxt = sum_r[46:0];
        end
        // ramp replaces the PID sum early in the move when the target is nonzero
        if (tick_r <= RAMP_TICKS) begin
          if (cfg.target_distance > 16'sd0) begin
            v_nxt = $signed({25'b0, tick_r, 18'b0});
          end else if (cfg.target_distance < 16'sd0) begin
            v_nxt = -$signed({25'b0, tick_r, 18'b0});
          end
        end
        state_nxt = S_CEIL_GO;
      end

      S_CEIL_GO: begin
        mreq.start  = 1'b1;
        mreq.mcand  = abs48(v_ext);
        mreq.mplier = OUT_SCALE;
        state_nxt   = S_CEIL;
      end

      S_CEIL: begin
        if (mrsp.done) begin
          if (pscale > ceil_q25) begin
            v_nxt = $signed({{14{cfg.speed_ceiling[15]}}, cfg.speed_ceiling, 17'b0});
          end
          state_nxt = S_FLOOR_GO;
        end
      end

      S_FLOOR_GO: begin
        mreq.start  = 1'b1;
        mreq.mcand  = abs48(v_ext);
        mreq.mplier = OUT_SCALE;
        state_nxt   = S_FLOOR;
      end

      S_FLOOR: begin
        if (mrsp.done) begin
          if (pscale < floor_q25) begin
            v_nxt = $signed({{14{cfg.speed_floor[15]}}, cfg.speed_floor, 17'b0});
          end
          state_nxt = S_TURN;
        end
      end

      S_TURN: begin
        turn_nxt  = {hwrap, 18'b0};
        state_nxt = S_OPS;
      end

      S_OPS: begin
        if (cfg.heading_hold) begin
          opl_nxt = v_ext + {{12{turn_r[35]}}, turn_r};
          opr_nxt = v_ext - {{12{turn_r[35]}}, turn_r};
        end else begin
          opl_nxt = v_ext;
          opr_nxt = v_ext;
        end
        state_nxt = S_CMDL_GO;
      end

      S_CMDL_GO: begin
        mreq.start  = 1'b1;
        mreq.mcand  = abs48(opl_r);
        mreq.mplier = OUT_SCALE;
        state_nxt   = S_CMD_L;
      end

      S_CMD_L: begin
        if (mrsp.done) begin
          lc_nxt      = to_cmd(opl_r[47], mrsp.product[61:25]);
          mreq.start  = 1'b1;
          mreq.mcand  = abs48(opr_r);
          mreq.mplier = OUT_SCALE;
          state_nxt   = S_CMD_R;
        end
      end

      S_CMD_R: begin
        if (mrsp.done) begin
          rc_nxt    = to_cmd(opr_r[47], mrsp.product[61:25]);
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        res_nxt = '0;
        res_nxt.command_is_voltage = cfg.heading_hold;
        if (done_r) begin
          res_nxt.finished    = 1'b1;
          res_nxt.stop_reason = reason_r;
        end else if (!(cfg.heading_hold && tick_r <= RAMP_TICKS)) begin
          res_nxt.left_command  = lc_r;
          res_nxt.right_command = rc_r;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_take) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      href_r      <= '0;
      poff_r      <= '0;
      prev_r      <= '0;
      integ_r     <= '0;
      tick_r      <= '0;
      settle_r    <= '0;
      stall_r     <= '0;
      done_r      <= 1'b0;
      reason_r    <= STOP_RUN;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      href_r      <= href_nxt;
      poff_r      <= poff_nxt;
      prev_r      <= prev_nxt;
      integ_r     <= integ_nxt;
      tick_r      <= tick_nxt;
      settle_r    <= settle_nxt;
      stall_r     <= stall_nxt;
      done_r      <= done_nxt;
      reason_r    <= reason_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    dist_r     <= dist_nxt;
    e_r        <= e_nxt;
    d_r        <= d_nxt;
    sum_r      <= sum_nxt;
    v_r        <= v_nxt;
    turn_r     <= turn_nxt;
    opl_r      <= opl_nxt;
    opr_r      <= opr_nxt;
    lc_r       <= lc_nxt;
    rc_r       <= rc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

/* hw/rtl/dpid_mul.sv */
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// Depends on dpid_pkg for the request and response structs and MUL_STEPS.
`default_nettype none
module dpid_mul import dpid_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic [71:0] acc_r, acc_nxt;
  logic [71:0] mc_r, mc_nxt;
  logic [23:0] mp_r, mp_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        last;

  assign last = (cnt_r == 5'(MUL_STEPS - 1));

  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      mc_nxt   = {24'b0, req.mcand};
      mp_nxt   = req.mplier;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt   = {mc_r[70:0], 1'b0};
      mp_nxt   = {1'b0, mp_r[23:1]};
      cnt_nxt  = cnt_r + 5'd1;
      busy_nxt = !last;
      done_nxt = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule
`default_nettype wire

/* hw/rtl/dpid_cfg.sv */
// Configuration register file of the distance PID controller.
// Depends on dpid_pkg for the register codes and the cfg_t struct.
`default_nettype none
module dpid_cfg import dpid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [23:0] wr_data,
  output cfg_t             cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_GAIN_P:          cfg_nxt.gain_p           = wr_data;
        REG_GAIN_I:          cfg_nxt.gain_i           = wr_data;
        REG_GAIN_D:          cfg_nxt.gain_d           = wr_data;
        REG_TARGET_DISTANCE: cfg_nxt.target_distance  = wr_data[15:0];
        REG_SPEED_CEILING:   cfg_nxt.speed_ceiling    = wr_data[15:0];
        REG_SPEED_FLOOR:     cfg_nxt.speed_floor      = wr_data[15:0];
        REG_SETTLE_TOL:      cfg_nxt.settle_tolerance = wr_data[15:0];
        REG_HEADING_HOLD:    cfg_nxt.heading_hold     = wr_data[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire
